>>> design/cl1g_pkg.sv
// ============================================================================
// cl1g_pkg: shared types, constants and color math for the L1 neighbor gradient
// Holds pixel and result types, register indexes, default geometry and the
// saturated L1 color distance used by the gradient datapath.
// ============================================================================
package cl1g_pkg;

    // Default geometry limits (line buffer depth and row counter range)
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Field widths
    localparam int CH_W         = 8;
    localparam int PIX_W        = 3 * CH_W;
    localparam int GRAD_W       = 8;
    localparam int COL_OUT_W    = 10;
    localparam int ROW_OUT_W    = 12;
    localparam int WIDTH_CFG_W  = 11;
    localparam int HEIGHT_CFG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Register reset values
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    localparam logic [GRAD_W-1:0] SAT_LIMIT = 8'd255;

    // Result slots produced by one pixel, in delivery order
    localparam int NUM_SLOTS  = 3;
    localparam int SLOT_ABOVE = 0;
    localparam int SLOT_LEFT  = 1;
    localparam int SLOT_SELF  = 2;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    // Position of the pixel in the window relative to the image border
    typedef struct packed {
        logic up_ok;
        logic up2_ok;
        logic left_ok;
        logic left2_ok;
        logic right_ok;
        logic last_row;
        logic last_col;
    } nbr_flags_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0]             mask;
        logic [NUM_SLOTS-1:0][GRAD_W-1:0] grad;
    } res_set_t;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Sum of absolute channel differences, clipped to the gradient range
    function automatic logic [GRAD_W-1:0] color_dist(input rgb_t p, input rgb_t q);
        logic [CH_W+1:0] sum;
        sum = {2'b00, abs_diff(p.red, q.red)}
            + {2'b00, abs_diff(p.green, q.green)}
            + {2'b00, abs_diff(p.blue, q.blue)};
        return (sum > (CH_W+2)'(SAT_LIMIT)) ? SAT_LIMIT : sum[GRAD_W-1:0];
    endfunction

    function automatic logic [GRAD_W-1:0] take_max(input logic [GRAD_W-1:0] g,
                                                   input logic [GRAD_W-1:0] d);
        return (d > g) ? d : g;
    endfunction

    // Last valid index for a programmed size: zero counts as one, clip at limit
    function automatic int last_index(input int value, input int limit);
        int idx;
        if (value == 0) begin
            idx = 0;
        end else if (value > limit) begin
            idx = limit - 1;
        end else begin
            idx = value - 1;
        end
        return idx;
    endfunction

endpackage

>>> design/cl1g_ram.sv
// ============================================================================
// cl1g_ram: generic single write port, single read port RAM
// Registered read with read enable; a read and a write to the same address
// in one cycle return the old contents.
// ============================================================================
module cl1g_ram
    import cl1g_pkg::*;
#(
    parameter int WIDTH = PIX_W,
    parameter int DEPTH = MAX_WIDTH_DEF
)(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/cl1g_gradient.sv
// ============================================================================
// cl1g_gradient: neighbor distance and maximum for one window position
// Computes the results of the pixel above, the pixel to the left and the
// pixel itself from the registered window; masks select which are due.
// ============================================================================
module cl1g_gradient
    import cl1g_pkg::*;
(
    input  rgb_t       cur,
    input  rgb_t       left,
    input  rgb_t       left2,
    input  rgb_t       up,
    input  rgb_t       up_left,
    input  rgb_t       up2,
    input  rgb_t       up_right,
    input  nbr_flags_t flags,
    output res_set_t   res
);

    logic [GRAD_W-1:0] d_up_cur;
    logic [GRAD_W-1:0] d_up_up2;
    logic [GRAD_W-1:0] d_up_ul;
    logic [GRAD_W-1:0] d_up_ur;
    logic [GRAD_W-1:0] d_left_cur;
    logic [GRAD_W-1:0] d_left_ul;
    logic [GRAD_W-1:0] d_left_l2;

    assign d_up_cur   = color_dist(up, cur);
    assign d_up_up2   = color_dist(up, up2);
    assign d_up_ul    = color_dist(up, up_left);
    assign d_up_ur    = color_dist(up, up_right);
    assign d_left_cur = color_dist(left, cur);
    assign d_left_ul  = color_dist(left, up_left);
    assign d_left_l2  = color_dist(left, left2);

    always_comb
    begin
        // Pixel above: down neighbor is the incoming pixel
        res.grad[SLOT_ABOVE] = take_max(
            take_max(d_up_cur, flags.up2_ok ? d_up_up2 : '0),
            take_max(flags.left_ok ? d_up_ul : '0, flags.right_ok ? d_up_ur : '0));
        // Pixel to the left on the last row: right neighbor just arrived
        res.grad[SLOT_LEFT] = take_max(
            d_left_cur,
            take_max(flags.up_ok ? d_left_ul : '0, flags.left2_ok ? d_left_l2 : '0));
        // Final pixel of the frame
        res.grad[SLOT_SELF] = take_max(flags.up_ok ? d_up_cur : '0,
                                       flags.left_ok ? d_left_cur : '0);

        res.mask[SLOT_ABOVE] = flags.up_ok;
        res.mask[SLOT_LEFT]  = flags.last_row && flags.left_ok;
        res.mask[SLOT_SELF]  = flags.last_row && flags.last_col;
    end

endmodule

>>> design/cl1g_result_queue.sv
// ============================================================================
// cl1g_result_queue: result register and serializer
// Holds up to three results of one pixel and delivers them one per
// transaction, lowest slot first.
// ============================================================================
module cl1g_result_queue
    import cl1g_pkg::*;
#(
    parameter int COL_W = $clog2(MAX_WIDTH_DEF),
    parameter int ROW_W = $clog2(MAX_HEIGHT_DEF)
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  res_set_t             load_set,
    input  logic [COL_W-1:0]     load_col,
    input  logic [ROW_W-1:0]     load_row,
    output logic                 free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [GRAD_W-1:0]    gradient,
    output logic [COL_OUT_W-1:0] column,
    output logic [ROW_OUT_W-1:0] row,
    output logic                 frame_end
);

    logic [NUM_SLOTS-1:0]             mask_reg;
    logic [NUM_SLOTS-1:0]             mask_next;
    logic [NUM_SLOTS-1:0][GRAD_W-1:0] grad_reg;
    logic [COL_W-1:0]                 col_reg;
    logic [ROW_W-1:0]                 row_reg;
    logic [NUM_SLOTS-1:0]             low_bit;
    logic [NUM_SLOTS-1:0]             mask_popped;
    logic                             pop;

    assign low_bit     = mask_reg & (~mask_reg + NUM_SLOTS'(1));
    assign mask_popped = mask_reg & ~low_bit;
    assign out_valid   = |mask_reg;
    assign pop         = out_valid && out_ready;
    assign free        = !out_valid || (out_ready && (mask_popped == '0));

    always_comb
    begin
        mask_next = mask_reg;
        if (load)
        begin
            mask_next = load_set.mask;
        end
        else if (pop)
        begin
            mask_next = mask_popped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grad_reg <= load_set.grad;
            col_reg  <= load_col;
            row_reg  <= load_row;
        end
    end

    always_comb
    begin
        if (low_bit[SLOT_ABOVE])
        begin
            gradient = grad_reg[SLOT_ABOVE];
        end
        else if (low_bit[SLOT_LEFT])
        begin
            gradient = grad_reg[SLOT_LEFT];
        end
        else
        begin
            gradient = grad_reg[SLOT_SELF];
        end
        column    = COL_OUT_W'(low_bit[SLOT_LEFT] ? (col_reg - COL_W'(1)) : col_reg);
        row       = ROW_OUT_W'(low_bit[SLOT_ABOVE] ? (row_reg - ROW_W'(1)) : row_reg);
        frame_end = low_bit[SLOT_SELF];
    end

endmodule

>>> design/color_l1_neighbor_gradient.sv
// ============================================================================
// color_l1_neighbor_gradient: 4-neighbor L1 color gradient on an RGB8 stream
// Line-buffered raster processor with one input register stage and one
// result stage; gives each pixel's largest saturated L1 distance to its
// in-image up, down, left and right neighbors.
// ============================================================================
// Pixels enter in raster order, one per transaction on the input channel, and
// the block accepts one pixel every clock as long as the result side keeps
// up. A pixel's result leaves when the pixel below it arrives; on the last
// row it also leaves when its right neighbor arrives, and the final pixel of
// the frame flushes its own result with frame_end set. Each pixel therefore
// yields zero to three results: the first row gives none, the rows between
// give one per pixel and run at one pixel per clock, the last row gives up
// to two per pixel and the final pixel up to three. The output channel,
// one result per clock while out_ready is high, sets those figures; the
// datapath itself takes one pixel per clock. A result is offered on the
// output once the pixel that completes it has passed the input stage
// registers into the result register. Two line buffers (one read and one
// write port each, read data registered) hold the previous row and the row
// before it; both are touched once per accepted pixel. The buffers start
// with undefined contents and need no clearing pass: a frame reads only
// rows it has already written. Writing image_width or image_height restarts
// the frame at row 0, column 0; write only while no results are pending. A
// size of zero counts as one and sizes above MAX_WIDTH or MAX_HEIGHT are clipped.
// ============================================================================
module color_l1_neighbor_gradient
    import cl1g_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // pixel input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CH_W-1:0]       red,
    input  logic [CH_W-1:0]       green,
    input  logic [CH_W-1:0]       blue,
    // result output channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [GRAD_W-1:0]     gradient,
    output logic [COL_OUT_W-1:0]  column,
    output logic [ROW_OUT_W-1:0]  row,
    output logic                  frame_end
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    // Geometry registers hold the last column and last row index
    logic [COL_W-1:0] last_col_reg;
    logic [ROW_W-1:0] last_row_reg;

    // Raster position of the next pixel
    logic [COL_W-1:0] col_cnt_reg;
    logic [COL_W-1:0] col_cnt_next;
    logic [ROW_W-1:0] row_cnt_reg;
    logic [ROW_W-1:0] row_cnt_next;

    // Input stage: window around the pixel being evaluated
    logic             s1_valid_reg;
    logic             s1_valid_next;
    rgb_t             cur_reg;
    rgb_t             left_reg;
    rgb_t             left2_reg;
    rgb_t             up_reg;
    rgb_t             up_left_reg;
    nbr_flags_t       flags_reg;
    nbr_flags_t       flags_next;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;

    rgb_t             in_pix;
    rgb_t             up_next;
    rgb_t             above_rd;
    rgb_t             two_above_rd;
    logic [COL_W-1:0] above_raddr;
    logic             in_fire;
    logic             s1_advance;
    logic             s2_free;
    res_set_t         res_set;

    assign in_pix     = {red, green, blue};
    assign s1_advance = s1_valid_reg && s2_free;
    assign in_ready   = !s1_valid_reg || s2_free;
    assign in_fire    = in_valid && in_ready;

    // ------------------------------------------------------------------------
    // Configuration and raster counters. A register write restarts the frame.
    // ------------------------------------------------------------------------
    always_comb
    begin
        col_cnt_next = col_cnt_reg + COL_W'(1);
        row_cnt_next = row_cnt_reg;
        if (col_cnt_reg == last_col_reg)
        begin
            // wrap to the next row, and to row 0 after the last row
            col_cnt_next = '0;
            row_cnt_next = (row_cnt_reg == last_row_reg) ? '0 : (row_cnt_reg + ROW_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= COL_W'(last_index(WIDTH_RESET, MAX_WIDTH));
            last_row_reg <= ROW_W'(last_index(HEIGHT_RESET, MAX_HEIGHT));
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    last_col_reg <= COL_W'(last_index(int'(cfg_data[WIDTH_CFG_W-1:0]),
                                                      MAX_WIDTH));
                end
                REG_IMAGE_HEIGHT:
                begin
                    last_row_reg <= ROW_W'(last_index(int'(cfg_data[HEIGHT_CFG_W-1:0]),
                                                      MAX_HEIGHT));
                end
                default:
                begin
                    last_col_reg <= last_col_reg;
                end
            endcase
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (in_fire)
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // ------------------------------------------------------------------------
    // Line buffers. The previous-row buffer is read one column ahead so the
    // right neighbor of the pixel above is ready with the window; at the end
    // of a row it reads column 0, which then already holds the new row and
    // becomes the pixel above at the start of the next row. For one-pixel
    // rows the pixel above is simply the previous pixel.
    // ------------------------------------------------------------------------
    assign above_raddr = (col_cnt_reg == last_col_reg) ? '0 : (col_cnt_reg + COL_W'(1));
    assign up_next     = (last_col_reg == '0) ? cur_reg : above_rd;

    cl1g_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_above_ram (
        .clk     (clk),
        .wr_en   (in_fire),
        .wr_addr (col_cnt_reg),
        .wr_data (in_pix),
        .rd_en   (in_fire),
        .rd_addr (above_raddr),
        .rd_data (above_rd)
    );

    // Same-address read and write: read returns the row before the one stored
    cl1g_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_two_above_ram (
        .clk     (clk),
        .wr_en   (in_fire),
        .wr_addr (col_cnt_reg),
        .wr_data (up_next),
        .rd_en   (in_fire),
        .rd_addr (col_cnt_reg),
        .rd_data (two_above_rd)
    );

    // ------------------------------------------------------------------------
    // Input stage. Shift the window on every accepted pixel and capture the
    // border flags of its position; hold everything while stalled.
    // ------------------------------------------------------------------------
    always_comb
    begin
        flags_next.up_ok    = (row_cnt_reg != '0);
        flags_next.up2_ok   = (row_cnt_reg > ROW_W'(1));
        flags_next.left_ok  = (col_cnt_reg != '0);
        flags_next.left2_ok = (col_cnt_reg > COL_W'(1));
        flags_next.right_ok = (col_cnt_reg != last_col_reg);
        flags_next.last_row = (row_cnt_reg == last_row_reg);
        flags_next.last_col = (col_cnt_reg == last_col_reg);
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cur_reg     <= in_pix;
            left_reg    <= cur_reg;
            left2_reg   <= left_reg;
            up_reg      <= up_next;
            up_left_reg <= up_reg;
            flags_reg   <= flags_next;
            s1_col_reg  <= col_cnt_reg;
            s1_row_reg  <= row_cnt_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Distance and maximum for the window, then the result stage.
    // ------------------------------------------------------------------------
    cl1g_gradient u_gradient (
        .cur      (cur_reg),
        .left     (left_reg),
        .left2    (left2_reg),
        .up       (up_reg),
        .up_left  (up_left_reg),
        .up2      (two_above_rd),
        .up_right (above_rd),
        .flags    (flags_reg),
        .res      (res_set)
    );

    cl1g_result_queue #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) u_result_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_advance),
        .load_set  (res_set),
        .load_col  (s1_col_reg),
        .load_row  (s1_row_reg),
        .free      (s2_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .gradient  (gradient),
        .column    (column),
        .row       (row),
        .frame_end (frame_end)
    );

endmodule

>>> design/cl1g_checker.sv
// ============================================================================
// cl1g_checker: port-level checks for color_l1_neighbor_gradient
// Watches the handshake and frame sequencing seen at the top-level ports.
// ============================================================================
module cl1g_checker
    import cl1g_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [GRAD_W-1:0]    gradient,
    input logic [COL_OUT_W-1:0] column,
    input logic [ROW_OUT_W-1:0] row,
    input logic                 frame_end
);

    logic seen_fe_reg;
    logic seen_fe_next;

    // Remember that the last delivered result closed a frame
    always_comb
    begin
        seen_fe_next = seen_fe_reg;
        if (out_valid && out_ready)
        begin
            seen_fe_next = frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_fe_reg <= 1'b0;
        end
        else
        begin
            seen_fe_reg <= seen_fe_next;
        end
    end

    // A stalled result holds
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(gradient) && $stable(column)
                                    && $stable(row) && $stable(frame_end);
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result changed or dropped while stalled");

    // Input backpressure only while a result waits
    property p_stall_cause;
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid;
    endproperty
    a_stall_cause: assert property (p_stall_cause)
        else $error("input stalled with no result pending");

    // The first result after a frame end belongs to the top-left pixel
    property p_frame_restart;
        @(posedge clk) disable iff (!rst_n)
        out_valid && seen_fe_reg |-> (row == '0) && (column == '0);
    endproperty
    a_frame_restart: assert property (p_frame_restart)
        else $error("new frame does not start at row 0, column 0");

endmodule

bind color_l1_neighbor_gradient cl1g_checker u_cl1g_checker (.*);
